@@ rtl/core/lzwbe_pkg.sv @@
// ----------------------------------------------------------------------------
// LZ window expander package
// Shared constants, the distance code table limits and the command record
// that passes from the classifying front end to the copy engine.
// ----------------------------------------------------------------------------
package lzwbe_pkg;

	localparam int WINDOW_SIZE   = 4096;
	localparam int POS_W         = $clog2(WINDOW_SIZE);
	localparam int SYMBOL_COUNT  = 314;
	localparam int LITERAL_LIMIT = 256;
	localparam int LEN_BIAS      = 253;
	localparam int SYM_W         = 9;
	localparam int LEN_W         = 6;
	localparam int TBU_W         = 3;
	localparam int CMD_DEPTH     = 4;

	localparam logic [7:0] SPACE_BYTE = 8'h20;

	localparam logic [7:0] HEAD_N2 = 8'h20;
	localparam logic [7:0] HEAD_N3 = 8'h50;
	localparam logic [7:0] HEAD_N4 = 8'h90;
	localparam logic [7:0] HEAD_N5 = 8'hC0;
	localparam logic [7:0] HEAD_N6 = 8'hF0;

	localparam logic [5:0] UPPER_N2 = 6'h01;
	localparam logic [5:0] UPPER_N3 = 6'h04;
	localparam logic [5:0] UPPER_N4 = 6'h0C;
	localparam logic [5:0] UPPER_N5 = 6'h18;

	typedef struct packed {
		logic             is_lit;
		logic [7:0]       lit_byte;
		logic [LEN_W-1:0] len;
		logic [POS_W-1:0] distance;
		logic [TBU_W-1:0] tbu;
	} cmd_t;

endpackage

@@ rtl/core/lzwbe_in_if.sv @@
// ----------------------------------------------------------------------------
// Symbol stream interface
// Carries one decoded symbol and the stream bits that follow it.
// ----------------------------------------------------------------------------
interface lzwbe_in_if;
	logic       valid;
	logic       ready;
	logic [8:0] symbol;
	logic [7:0] offset_head;
	logic [5:0] offset_tail;

	modport source (output valid, symbol, offset_head, offset_tail, input ready);
	modport sink (input valid, symbol, offset_head, offset_tail, output ready);
endinterface

@@ rtl/core/lzwbe_out_if.sv @@
// ----------------------------------------------------------------------------
// Byte stream interface
// Carries one decompressed byte per transfer with its framing fields.
// ----------------------------------------------------------------------------
interface lzwbe_out_if;
	logic       valid;
	logic       ready;
	logic [7:0] out_byte;
	logic       last;
	logic [2:0] tail_bits_used;

	modport source (output valid, out_byte, last, tail_bits_used, input ready);
	modport sink (input valid, out_byte, last, tail_bits_used, output ready);
endinterface

@@ rtl/core/lzwbe_front.sv @@
// ----------------------------------------------------------------------------
// LZ window expander front end
// Accepts symbols, drops those out of range, and turns the rest into literal
// or copy commands with the distance decoded from the stream bits.
// ----------------------------------------------------------------------------
module lzwbe_front (
	input  logic                clk,
	input  logic                arst_n,
	lzwbe_in_if.sink            sym_stream,
	output logic                cmd_valid,
	input  logic                cmd_ready,
	output lzwbe_pkg::cmd_t     cmd
);

	logic                            cmd_v_q;
	lzwbe_pkg::cmd_t                 cmd_q;
	lzwbe_pkg::cmd_t                 cmd_next;
	logic [2:0]                      n_bits;
	logic [5:0]                      upper;
	logic [5:0]                      low6;
	logic [7:0]                      head_diff;
	logic [lzwbe_pkg::SYM_W-1:0]     len_full;
	logic                            in_range;
	logic                            is_lit;

	always_comb begin
		head_diff = '0;
		n_bits    = 3'd1;
		upper     = '0;
		low6      = '0;
		case (sym_stream.offset_head) inside
			[8'h00:8'h1F]: begin
				n_bits = 3'd1;
				upper  = '0;
				low6   = {sym_stream.offset_head[4:0], sym_stream.offset_tail[5]};
			end
			[8'h20:8'h4F]: begin
				head_diff = sym_stream.offset_head - lzwbe_pkg::HEAD_N2;
				n_bits    = 3'd2;
				upper     = 6'(head_diff >> 4) + lzwbe_pkg::UPPER_N2;
				low6      = {sym_stream.offset_head[3:0], sym_stream.offset_tail[5:4]};
			end
			[8'h50:8'h8F]: begin
				head_diff = sym_stream.offset_head - lzwbe_pkg::HEAD_N3;
				n_bits    = 3'd3;
				upper     = 6'(head_diff >> 3) + lzwbe_pkg::UPPER_N3;
				low6      = {sym_stream.offset_head[2:0], sym_stream.offset_tail[5:3]};
			end
			[8'h90:8'hBF]: begin
				head_diff = sym_stream.offset_head - lzwbe_pkg::HEAD_N4;
				n_bits    = 3'd4;
				upper     = 6'(head_diff >> 2) + lzwbe_pkg::UPPER_N4;
				low6      = {sym_stream.offset_head[1:0], sym_stream.offset_tail[5:2]};
			end
			[8'hC0:8'hEF]: begin
				head_diff = sym_stream.offset_head - lzwbe_pkg::HEAD_N5;
				n_bits    = 3'd5;
				upper     = 6'(head_diff >> 1) + lzwbe_pkg::UPPER_N5;
				low6      = {sym_stream.offset_head[0], sym_stream.offset_tail[5:1]};
			end
			default: begin
				head_diff = sym_stream.offset_head - lzwbe_pkg::HEAD_N5;
				n_bits    = 3'd6;
				upper     = head_diff[5:0];
				low6      = sym_stream.offset_tail;
			end
		endcase
	end

	assign in_range = sym_stream.symbol < lzwbe_pkg::SYM_W'(lzwbe_pkg::SYMBOL_COUNT);
	assign is_lit   = sym_stream.symbol < lzwbe_pkg::SYM_W'(lzwbe_pkg::LITERAL_LIMIT);
	assign len_full = sym_stream.symbol - lzwbe_pkg::SYM_W'(lzwbe_pkg::LEN_BIAS);

	always_comb begin
		cmd_next.is_lit   = is_lit;
		cmd_next.lit_byte = sym_stream.symbol[7:0];
		cmd_next.len      = len_full[lzwbe_pkg::LEN_W-1:0];
		cmd_next.distance = {upper, low6};
		cmd_next.tbu      = is_lit ? '0 : n_bits;
	end

	assign sym_stream.ready = !cmd_v_q || cmd_ready;
	assign cmd_valid        = cmd_v_q;
	assign cmd              = cmd_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			cmd_v_q <= 1'b0;
		end else if (sym_stream.ready) begin
			cmd_v_q <= sym_stream.valid && in_range;
		end
	end

	always_ff @(posedge clk) begin
		if (sym_stream.ready && sym_stream.valid) begin
			cmd_q <= cmd_next;
		end
	end

endmodule

@@ rtl/core/lzwbe_cmd_fifo.sv @@
// ----------------------------------------------------------------------------
// LZ window expander command queue
// A short register queue that decouples the front end from the copy engine.
// ----------------------------------------------------------------------------
module lzwbe_cmd_fifo #(
	parameter int DEPTH = lzwbe_pkg::CMD_DEPTH
) (
	input  logic            clk,
	input  logic            arst_n,
	input  logic            push_valid,
	output logic            push_ready,
	input  lzwbe_pkg::cmd_t push_data,
	output logic            pop_valid,
	input  logic            pop,
	output lzwbe_pkg::cmd_t pop_data
);

	localparam int PTR_W = (DEPTH > 1) ? $clog2(DEPTH) : 1;
	localparam int CNT_W = $clog2(DEPTH + 1);

	lzwbe_pkg::cmd_t  entry_q [DEPTH];
	logic [PTR_W-1:0] wr_ptr_q;
	logic [PTR_W-1:0] rd_ptr_q;
	logic [CNT_W-1:0] count_q;
	logic             push;

	assign push_ready = count_q != CNT_W'(DEPTH);
	assign pop_valid  = count_q != '0;
	assign pop_data   = entry_q[rd_ptr_q];
	assign push       = push_valid && push_ready;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wr_ptr_q <= '0;
			rd_ptr_q <= '0;
			count_q  <= '0;
		end else begin
			if (push) begin
				wr_ptr_q <= (wr_ptr_q == PTR_W'(DEPTH - 1)) ? '0 : wr_ptr_q + 1'b1;
			end
			if (pop) begin
				rd_ptr_q <= (rd_ptr_q == PTR_W'(DEPTH - 1)) ? '0 : rd_ptr_q + 1'b1;
			end
			if (push && !pop) begin
				count_q <= count_q + 1'b1;
			end else if (pop && !push) begin
				count_q <= count_q - 1'b1;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (push) begin
			entry_q[wr_ptr_q] <= push_data;
		end
	end

	a_pop_needs_entry: assert property (@(posedge clk) disable iff (!arst_n)
		pop |-> count_q != '0)
		else $error("command popped from an empty queue");

	a_count_tracks_push: assert property (@(posedge clk) disable iff (!arst_n)
		(push && !pop) |=> count_q == CNT_W'($past(count_q) + 1'b1))
		else $error("queue fill count lost a transfer");

endmodule

@@ rtl/core/lzwbe_back.sv @@
// ----------------------------------------------------------------------------
// LZ window expander copy engine
// Executes literal and copy commands against the history window, one byte a
// cycle unless stalled, with forwarding for copies that overlap their output.
// ----------------------------------------------------------------------------
module lzwbe_back (
	input  logic            clk,
	input  logic            arst_n,
	input  logic            cmd_valid,
	output logic            cmd_pop,
	input  lzwbe_pkg::cmd_t cmd,
	lzwbe_out_if.source     byte_stream
);

	localparam int POS_W = lzwbe_pkg::POS_W;
	localparam int LEN_W = lzwbe_pkg::LEN_W;
	localparam int TBU_W = lzwbe_pkg::TBU_W;

	logic [7:0]       window_mem [lzwbe_pkg::WINDOW_SIZE];

	logic [POS_W-1:0] wp_q;
	logic             wrapped_q;
	logic             busy_q;
	logic [POS_W-1:0] ra_q;
	logic [LEN_W-1:0] rem_q;
	logic [TBU_W-1:0] tbu_q;

	logic             v_s1;
	logic             lit_s1;
	logic [7:0]       lit_byte_s1;
	logic             fwd_s1;
	logic [7:0]       fwd_byte_s1;
	logic             filled_s1;
	logic [7:0]       rdata_s1;
	logic             last_s1;
	logic [TBU_W-1:0] tbu_s1;

	logic             out_v_q;
	logic [7:0]       out_byte_q;
	logic             out_last_q;
	logic [TBU_W-1:0] out_tbu_q;

	logic             advance;
	logic             move;
	logic             issue_ok;
	logic             issue;
	logic             issue_rd;
	logic [7:0]       byte_s1;
	logic [POS_W-1:0] ra_first;
	logic [POS_W-1:0] rd_addr;

	assign advance  = !out_v_q || byte_stream.ready;
	assign move     = v_s1 && advance;
	assign issue_ok = !v_s1 || advance;
	assign cmd_pop  = issue_ok && !busy_q && cmd_valid;
	assign issue    = (issue_ok && busy_q) || cmd_pop;
	assign issue_rd = (issue_ok && busy_q) || (cmd_pop && !cmd.is_lit);
	assign ra_first = wp_q + POS_W'(move) - cmd.distance - 1'b1;
	assign rd_addr  = busy_q ? ra_q : ra_first;

	always_comb begin
		if (lit_s1) begin
			byte_s1 = lit_byte_s1;
		end else if (fwd_s1) begin
			byte_s1 = fwd_byte_s1;
		end else if (filled_s1) begin
			byte_s1 = rdata_s1;
		end else begin
			byte_s1 = lzwbe_pkg::SPACE_BYTE;
		end
	end

	always_ff @(posedge clk) begin
		if (move) begin
			window_mem[wp_q] <= byte_s1;
		end
		if (issue_rd) begin
			rdata_s1 <= window_mem[rd_addr];
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wp_q      <= '0;
			wrapped_q <= 1'b0;
			busy_q    <= 1'b0;
			v_s1      <= 1'b0;
			out_v_q   <= 1'b0;
		end else begin
			if (move) begin
				wp_q <= wp_q + 1'b1;
				if (wp_q == '1) begin
					wrapped_q <= 1'b1;
				end
			end
			if (issue_ok && busy_q && rem_q == LEN_W'(1)) begin
				busy_q <= 1'b0;
			end else if (cmd_pop && !cmd.is_lit) begin
				busy_q <= 1'b1;
			end
			if (issue) begin
				v_s1 <= 1'b1;
			end else if (move) begin
				v_s1 <= 1'b0;
			end
			if (advance) begin
				out_v_q <= v_s1;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (issue_ok && busy_q) begin
			rem_q <= rem_q - 1'b1;
			ra_q  <= ra_q + 1'b1;
		end else if (cmd_pop && !cmd.is_lit) begin
			rem_q <= cmd.len - 1'b1;
			ra_q  <= ra_first + 1'b1;
			tbu_q <= cmd.tbu;
		end
		if (issue) begin
			lit_s1      <= !busy_q && cmd.is_lit;
			lit_byte_s1 <= cmd.lit_byte;
			last_s1     <= busy_q ? (rem_q == LEN_W'(1)) : cmd.is_lit;
			tbu_s1      <= busy_q ? tbu_q : cmd.tbu;
			fwd_s1      <= move && (rd_addr == wp_q);
			fwd_byte_s1 <= byte_s1;
			filled_s1   <= wrapped_q || (rd_addr < wp_q);
		end
		if (move) begin
			out_byte_q <= byte_s1;
			out_last_q <= last_s1;
			out_tbu_q  <= tbu_s1;
		end
	end

	assign byte_stream.valid          = out_v_q;
	assign byte_stream.out_byte       = out_byte_q;
	assign byte_stream.last           = out_last_q;
	assign byte_stream.tail_bits_used = out_tbu_q;

	a_busy_has_work: assert property (@(posedge clk) disable iff (!arst_n)
		busy_q |-> rem_q != '0)
		else $error("copy engine busy with no bytes left");

	a_stage_holds: assert property (@(posedge clk) disable iff (!arst_n)
		(v_s1 && !advance) |=> v_s1 && $stable(last_s1) && $stable(tbu_s1))
		else $error("read stage changed while the output was stalled");

	a_write_advances: assert property (@(posedge clk) disable iff (!arst_n)
		move |=> wp_q == POS_W'($past(wp_q) + 1'b1))
		else $error("write position did not follow a delivered byte");

endmodule

@@ rtl/core/lz_window_backref_expander_unit.sv @@
// ----------------------------------------------------------------------------
// LZ window back-reference expander
// Expands decoded literal and match symbols into bytes through a 4096-byte
// history window.
//
// sym_stream takes one decoded symbol with the next 14 stream bits per
// transfer. Symbols below 256 give one byte; symbols from 256 to 313 copy
// symbol-253 bytes from the window. Larger symbols are taken and dropped.
// byte_stream gives one byte per transfer, with last on the final byte of
// each symbol and the number of tail bits the distance used.
// The copy engine delivers one byte per cycle unless the output stalls,
// limited by the single read port of the window memory; a match copies
// 3 to 60 bytes. A four-entry command queue lets the front end keep
// taking symbols while a copy runs.
// After reset the window reads as spaces: entries not yet written since
// reset are recognised from the write position, so no clearing pass is
// needed. A stalled receiver holds the output register and, behind it, the
// copy engine, the queue and finally sym_stream.
// ----------------------------------------------------------------------------
module lz_window_backref_expander_unit #(
	parameter int CMD_DEPTH = lzwbe_pkg::CMD_DEPTH
) (
	input  logic        clk,
	input  logic        arst_n,
	lzwbe_in_if.sink    sym_stream,
	lzwbe_out_if.source byte_stream
);

	logic            front_valid;
	logic            front_ready;
	lzwbe_pkg::cmd_t front_cmd;
	logic            queue_valid;
	logic            queue_pop;
	lzwbe_pkg::cmd_t queue_cmd;

	lzwbe_front u_front (
		.clk        (clk),
		.arst_n     (arst_n),
		.sym_stream (sym_stream),
		.cmd_valid  (front_valid),
		.cmd_ready  (front_ready),
		.cmd        (front_cmd)
	);

	lzwbe_cmd_fifo #(
		.DEPTH (CMD_DEPTH)
	) u_cmd_fifo (
		.clk        (clk),
		.arst_n     (arst_n),
		.push_valid (front_valid),
		.push_ready (front_ready),
		.push_data  (front_cmd),
		.pop_valid  (queue_valid),
		.pop        (queue_pop),
		.pop_data   (queue_cmd)
	);

	lzwbe_back u_back (
		.clk         (clk),
		.arst_n      (arst_n),
		.cmd_valid   (queue_valid),
		.cmd_pop     (queue_pop),
		.cmd         (queue_cmd),
		.byte_stream (byte_stream)
	);

endmodule
